// File: sv/smav_pkg.sv
// Shared types, constants and helpers for the soil moisture valve decision block.
`timescale 1ns / 1ps

package smav_pkg;

  // Channel count default and field widths
  localparam int CHANNELS_DEF = 3;
  localparam int CAL_W        = 11;
  localparam int SAMPLE_W     = 10;
  localparam int CHAN_W       = 2;
  localparam int PCT_W        = 7;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 11;

  // Reset values of the config registers
  localparam logic [CAL_W-1:0] FLOOR_RESET = 11'd200;
  localparam logic [CAL_W-1:0] CEIL_RESET  = 11'd1300;
  localparam logic [PCT_W-1:0] THR_RESET   = 7'd50;
  localparam int               THR_COUNT   = 3;

  // Percent scale
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // Calibration reset values per channel; higher channels use the last entry
  localparam logic [CAL_W-1:0] LOW_RESET  [THR_COUNT] = '{11'd580, 11'd995, 11'd300};
  localparam logic [CAL_W-1:0] HIGH_RESET [THR_COUNT] = '{11'd1000, 11'd1023, 11'd600};

  // Config register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FLOOR = 3'd0,
    REG_CEIL  = 3'd1,
    REG_THR0  = 3'd2,
    REG_THR1  = 3'd3,
    REG_THR2  = 3'd4
  } reg_idx_t;

  // Microcode operations, one per program step
  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_LOAD = 3'd1,
    OP_LOW  = 3'd2,
    OP_HIGH = 3'd3,
    OP_SPAN = 3'd4,
    OP_DIV  = 3'd5,
    OP_DEC  = 3'd6,
    OP_EMIT = 3'd7
  } op_t;

  // Datapath status seen by the sequencer's jump conditions
  typedef struct packed {
    logic no_in;   // no item taken this cycle
    logic skip;    // channel out of range or unavailable
    logic empty;   // calibration span is empty
    logic cnt_nz;  // divider iterations remain
    logic busy;    // result register still occupied
  } flags_t;

  // Input and result items
  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                available;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [PCT_W-1:0]  moisture_percent;
    logic              valve_open;
    logic              valve_changed;
    logic              skipped;
  } out_item_t;

  // Calibration reset value lookups
  function automatic logic [CAL_W-1:0] low_reset(input int c);
    low_reset = LOW_RESET[(c < THR_COUNT) ? c : THR_COUNT - 1];
  endfunction

  function automatic logic [CAL_W-1:0] high_reset(input int c);
    high_reset = HIGH_RESET[(c < THR_COUNT) ? c : THR_COUNT - 1];
  endfunction

endpackage

// File: sv/smav_chan_if.sv
// Valid/ready channel interface carrying one item per handshake.
`timescale 1ns / 1ps

interface smav_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/smav_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps

module smav_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  smav_pkg::flags_t flags,
  output smav_pkg::op_t    op
);

  typedef enum logic [2:0] {
    C_NEVER = 3'd0,
    C_NO_IN = 3'd1,
    C_SKIP  = 3'd2,
    C_EMPTY = 3'd3,
    C_CNT   = 3'd4,
    C_BUSY  = 3'd5
  } cond_t;

  typedef struct packed {
    smav_pkg::op_t op;
    cond_t         cond;
    logic [2:0]    target;
  } uword_t;

  logic [2:0] pc_r, pc_nxt;
  uword_t     uw;
  logic       taken;

  // Program: taken jump goes to target, otherwise to the next step
  always_comb begin
    unique case (pc_r)
      3'd0:    uw = '{smav_pkg::OP_IDLE, C_NO_IN, 3'd0};  // wait for an item
      3'd1:    uw = '{smav_pkg::OP_LOAD, C_SKIP,  3'd7};  // fetch channel state
      3'd2:    uw = '{smav_pkg::OP_LOW,  C_NEVER, 3'd0};  // widen lower bound
      3'd3:    uw = '{smav_pkg::OP_HIGH, C_NEVER, 3'd0};  // widen upper bound, clamp
      3'd4:    uw = '{smav_pkg::OP_SPAN, C_EMPTY, 3'd6};  // numerator, span
      3'd5:    uw = '{smav_pkg::OP_DIV,  C_CNT,   3'd5};  // one quotient bit
      3'd6:    uw = '{smav_pkg::OP_DEC,  C_NEVER, 3'd0};  // valve decision
      default: uw = '{smav_pkg::OP_EMIT, C_BUSY,  3'd7};  // hand off result
    endcase
  end

  // Jump condition select
  always_comb begin
    unique case (uw.cond)
      C_NO_IN: taken = flags.no_in;
      C_SKIP:  taken = flags.skip;
      C_EMPTY: taken = flags.empty;
      C_CNT:   taken = flags.cnt_nz;
      C_BUSY:  taken = flags.busy;
      default: taken = 1'b0;
    endcase
  end

  // Last step wraps back to idle
  assign pc_nxt = taken ? uw.target : pc_r + 3'd1;
  assign op     = uw.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 3'd0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/soil_moisture_autorange_valve_decide.sv
// Top level: auto-ranging soil moisture normalizer with per-channel valve decision.
`timescale 1ns / 1ps

// Each item carries one 10-bit soil sample for a channel. The channel's
// calibration bounds widen toward the sample (limited by the floor and ceiling
// registers), the clamped sample is mapped to 0..100 percent, and the channel's
// valve opens below its threshold or closes above it. One result item comes out
// for every input item. The percent comes from a bit-serial divider loop; an
// empty calibration span skips the divider, and a skipped item (channel
// unavailable or out of range) skips the whole calibration and percent path.
// The next item is accepted once the previous one has reached the result
// register, so a held result only delays the block when a second one is
// ready behind it.
// Config registers may be written only while no item is in flight.
module soil_moisture_autorange_valve_decide #(
  parameter int CHANNELS = smav_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  smav_chan_if.sink                           in_ch,
  smav_chan_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [smav_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [smav_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CAL_W = smav_pkg::CAL_W;
  localparam int PCT_W = smav_pkg::PCT_W;
  localparam int NUM_W = CAL_W + PCT_W;

  // Config registers
  logic [CAL_W-1:0] floor_r;
  logic [CAL_W-1:0] ceil_r;
  logic [PCT_W-1:0] thr_r [smav_pkg::THR_COUNT];

  // Per-channel state
  logic [CAL_W-1:0] low_cal_r  [CHANNELS];
  logic [CAL_W-1:0] high_cal_r [CHANNELS];
  logic             valve_r    [CHANNELS];

  // Working registers for the item in flight
  logic [smav_pkg::CHAN_W-1:0] ch_r;
  logic                        avail_r;
  logic                        skip_r;
  logic [CH_W-1:0]             idx_r;
  logic [CAL_W-1:0]            x_r, lo_r, hi_r;
  logic [CAL_W-1:0]            den_r;
  logic [NUM_W-1:0]            rem_r;
  logic [2:0]                  cnt_r;
  logic [PCT_W-1:0]            pct_r;
  logic [PCT_W-1:0]            thr_sel_r;
  logic                        vopen_r;
  logic                        changed_r;

  // Result register
  logic                out_valid_r;
  smav_pkg::out_item_t out_item_r;

  smav_pkg::op_t    op;
  smav_pkg::flags_t flags;
  logic             in_fire;
  logic             busy;
  logic             in_range;
  logic [1:0]       thr_idx;
  logic             dec_chg;

  // Bound and divider combinational terms
  logic [CAL_W-1:0] hi_n, x_h, x_c;
  logic [CAL_W-1:0] diff;
  logic [NUM_W-1:0] sub;
  logic             ge;

  assign in_ch.ready = (op == smav_pkg::OP_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign busy        = out_valid_r && !out_ch.ready;
  assign in_range    = int'(ch_r) < CHANNELS;
  assign thr_idx     = (ch_r == 2'd3) ? 2'd2 : ch_r;

  assign flags.no_in  = !in_fire;
  assign flags.skip   = !in_range || !avail_r;
  assign flags.empty  = !(hi_r > lo_r);
  assign flags.cnt_nz = (cnt_r != 3'd0);
  assign flags.busy   = busy;

  smav_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  // Upper bound widening followed by the final clamp
  always_comb begin
    hi_n = hi_r;
    x_h  = x_r;
    if (x_r > hi_r) begin
      if (x_r < ceil_r) hi_n = x_r;
      else              x_h  = hi_r;
    end
    x_c = (x_h < lo_r) ? lo_r : x_h;
    x_c = (x_c > hi_n) ? hi_n : x_c;
  end

  assign diff = hi_r - x_r;
  assign sub  = NUM_W'(den_r) << cnt_r;
  assign ge   = rem_r >= sub;

  // Valve toggles when the percent crosses the threshold against its state
  assign dec_chg = (pct_r < thr_sel_r && !vopen_r) || (pct_r > thr_sel_r && vopen_r);

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= smav_pkg::FLOOR_RESET;
      ceil_r  <= smav_pkg::CEIL_RESET;
      for (int t = 0; t < smav_pkg::THR_COUNT; t++) thr_r[t] <= smav_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        smav_pkg::REG_FLOOR: floor_r  <= cfg_wdata;
        smav_pkg::REG_CEIL:  ceil_r   <= cfg_wdata;
        smav_pkg::REG_THR0:  thr_r[0] <= cfg_wdata[PCT_W-1:0];
        smav_pkg::REG_THR1:  thr_r[1] <= cfg_wdata[PCT_W-1:0];
        smav_pkg::REG_THR2:  thr_r[2] <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel calibration and valve state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        low_cal_r[c]  <= smav_pkg::low_reset(c);
        high_cal_r[c] <= smav_pkg::high_reset(c);
        valve_r[c]    <= 1'b0;
      end
    end else begin
      if (op == smav_pkg::OP_SPAN) begin
        low_cal_r[idx_r]  <= lo_r;
        high_cal_r[idx_r] <= hi_r;
      end
      if (op == smav_pkg::OP_DEC) valve_r[idx_r] <= vopen_r ^ dec_chg;
    end
  end

  // Datapath driven by the current microcode step
  always_ff @(posedge clk) begin
    unique case (op)
      smav_pkg::OP_IDLE: begin
        if (in_fire) begin
          ch_r    <= in_ch.payload.channel;
          x_r     <= CAL_W'(in_ch.payload.sample);
          avail_r <= in_ch.payload.available;
        end
      end
      smav_pkg::OP_LOAD: begin
        idx_r     <= CH_W'(ch_r);
        lo_r      <= low_cal_r[CH_W'(ch_r)];
        hi_r      <= high_cal_r[CH_W'(ch_r)];
        vopen_r   <= in_range ? valve_r[CH_W'(ch_r)] : 1'b0;
        thr_sel_r <= thr_r[thr_idx];
        skip_r    <= !in_range || !avail_r;
        pct_r     <= '0;
        changed_r <= 1'b0;
      end
      smav_pkg::OP_LOW: begin
        if (x_r < lo_r) begin
          if (x_r > floor_r) lo_r <= x_r;
          else               x_r  <= lo_r;
        end
      end
      smav_pkg::OP_HIGH: begin
        hi_r <= hi_n;
        x_r  <= x_c;
      end
      smav_pkg::OP_SPAN: begin
        rem_r <= NUM_W'(diff) * NUM_W'(smav_pkg::PCT_SCALE);
        den_r <= hi_r - lo_r;
        cnt_r <= 3'(PCT_W - 1);
      end
      smav_pkg::OP_DIV: begin
        // Restoring division, one quotient bit per step, MSB first
        if (ge) rem_r <= rem_r - sub;
        pct_r <= {pct_r[PCT_W-2:0], ge};
        cnt_r <= cnt_r - 3'd1;
      end
      smav_pkg::OP_DEC: begin
        // changed_r marks a toggle; the new state is vopen_r ^ changed_r
        changed_r <= dec_chg;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == smav_pkg::OP_EMIT && !busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == smav_pkg::OP_EMIT && !busy) begin
      out_item_r.out_channel      <= ch_r;
      out_item_r.moisture_percent <= pct_r;
      out_item_r.valve_open       <= vopen_r ^ changed_r;
      out_item_r.valve_changed    <= changed_r;
      out_item_r.skipped          <= skip_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // Checks
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.skipped |->
      out_ch.payload.moisture_percent == '0 && !out_ch.payload.valve_changed)
    else $error("skipped result carries a percent or a valve change");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.payload.moisture_percent <= smav_pkg::PCT_SCALE)
    else $error("moisture percent above full scale");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> op == smav_pkg::OP_LOAD)
    else $error("accepted item not followed by state fetch");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    op == smav_pkg::OP_SPAN && !flags.empty |=> op == smav_pkg::OP_DIV && cnt_r == 3'(PCT_W - 1))
    else $error("divider not started with full iteration count");

endmodule
